FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// assertion helpers shared by the rtl files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// immediate-cycle implication, checked out of reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/bdpt_pkg.sv
// ----------------------------------------------------------------------------
// bdpt_pkg
// types and constants of the button debounce and press timer
// ----------------------------------------------------------------------------
package bdpt_pkg;

    localparam logic [15:0] DEBOUNCE_RESET = 16'd40;

    // register indexes on the configuration port
    localparam logic REG_DEBOUNCE_LIMIT = 1'b0;

    typedef enum logic [1:0] {
        PH_UP      = 2'd0,
        PH_FALLING = 2'd1,
        PH_DOWN    = 2'd2,
        PH_RISING  = 2'd3
    } t_phase;

    // one update tick, lowest field in the lowest bits
    typedef struct packed {
        logic [31:0] now_ticks;
        logic        button_level;
    } t_item;

    // one result, lowest field in the lowest bits
    typedef struct packed {
        logic [31:0] press_duration;
        logic        release_event;
        logic        press_event;
        t_phase      debounced_phase;
    } t_result;

endpackage

FILE: hdl/button_debounce_press_timer.sv
// ----------------------------------------------------------------------------
// button_debounce_press_timer
// debounced active-low button with press length measurement
// ----------------------------------------------------------------------------
// pipeline: an accepted tick beat goes to the input register, then into the
//   result register; throughput: one tick per cycle while the result side does
//   not stall, set by the single-pass step logic between the two registers
// reset: synchronous, clears the phase, both counters, the timestamps and
//   the stage valids, and loads the debounce limit with 40
`include "assert_macros.svh"

module button_debounce_press_timer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // button_level, now_ticks[31:0], zero pad
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // debounced_phase[1:0], press_event,
                                     // release_event, press_duration[31:0], zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bdpt_pkg::*;

    logic        r_in_vld;
    t_item       r_in_item;
    logic        r_out_vld;
    t_result     r_out_data;
    t_result     w_result;
    logic [15:0] w_limit;
    logic        w_adv;
    logic        w_s_fire;
    logic        w_step;

    // output register frees up when empty or being taken
    assign w_adv      = !r_out_vld || i_m_tready;
    assign o_s_tready = !r_in_vld || w_adv;
    assign w_s_fire   = i_s_tvalid && o_s_tready;
    assign w_step     = r_in_vld && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_s_tready) r_in_vld  <= i_s_tvalid;
            if (w_adv)      r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_fire) r_in_item  <= i_s_tdata[32:0];
        if (w_step)   r_out_data <= w_result;
    end

    bdpt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_limit (w_limit)
    );

    bdpt_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_step),
        .i_item   (r_in_item),
        .i_limit  (w_limit),
        .o_result (w_result)
    );

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {4'd0, r_out_data};

    `ASSERT_IMPL(a_stall_only_when_full, i_clk, i_rst_n, !o_s_tready,
        r_in_vld && r_out_vld && !i_m_tready, "input stalled with room in the pipe")
    `ASSERT_NEXT(a_accept_fills_stage, i_clk, i_rst_n, w_s_fire,
        r_in_vld, "accepted beat did not reach the input register")
    `ASSERT_NEXT(a_step_fills_output, i_clk, i_rst_n, w_step,
        r_out_vld, "stepped beat did not reach the result register")

endmodule

FILE: hdl/bdpt_cfg.sv
// ----------------------------------------------------------------------------
// bdpt_cfg
// apb register holding the debounce limit
// ----------------------------------------------------------------------------
module bdpt_cfg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] o_limit
);
    import bdpt_pkg::*;

    logic [15:0] r_limit;
    logic        w_sel_limit;

    // word index sits above the byte offset
    assign w_sel_limit = (paddr[2] == REG_DEBOUNCE_LIMIT);
    assign pready      = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= DEBOUNCE_RESET;
        end else if (psel && penable && pwrite && pready && w_sel_limit) begin
            r_limit <= pwdata[15:0];
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (w_sel_limit) begin
            prdata = {16'd0, r_limit};
        end
    end

    assign o_limit = r_limit;

endmodule

FILE: hdl/bdpt_fsm.sv
// ----------------------------------------------------------------------------
// bdpt_fsm
// four-phase debounce machine with press timestamp and duration
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bdpt_fsm (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  bdpt_pkg::t_item   i_item,
    input  logic [15:0]       i_limit,
    output bdpt_pkg::t_result o_result
);
    import bdpt_pkg::*;

    t_phase      r_phase,       n_phase;
    logic [15:0] r_fall_cnt,    n_fall_cnt;
    logic [15:0] r_rise_cnt,    n_rise_cnt;
    logic [31:0] r_press_start, n_press_start;
    logic [31:0] r_last_dur,    n_last_dur;
    logic        w_pressed;
    logic        w_fall_done;
    logic        w_rise_done;
    logic        w_press;
    logic        w_release;

    assign w_pressed   = ~i_item.button_level;
    assign w_fall_done = (r_fall_cnt >= i_limit);
    assign w_rise_done = (r_rise_cnt >= i_limit);

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_UP: begin
                if (w_pressed) n_phase = PH_FALLING;
            end
            PH_FALLING: begin
                if (w_fall_done) n_phase = w_pressed ? PH_DOWN : PH_UP;
            end
            PH_DOWN: begin
                if (!w_pressed) n_phase = PH_RISING;
            end
            PH_RISING: begin
                if (w_rise_done) n_phase = w_pressed ? PH_DOWN : PH_UP;
            end
            default: begin
                n_phase = PH_UP;
            end
        endcase
    end

    // counters, events and timer
    always_comb begin
        n_fall_cnt    = r_fall_cnt;
        n_rise_cnt    = r_rise_cnt;
        n_press_start = r_press_start;
        n_last_dur    = r_last_dur;
        w_press       = 1'b0;
        w_release     = 1'b0;
        case (r_phase)
            PH_FALLING: begin
                // cleared on a decision, then counted on the same tick
                n_fall_cnt = (w_fall_done ? 16'd0 : r_fall_cnt) + 16'd1;
                if (w_fall_done && w_pressed) begin
                    w_press       = 1'b1;
                    n_press_start = i_item.now_ticks;
                end
            end
            PH_RISING: begin
                n_rise_cnt = (w_rise_done ? 16'd0 : r_rise_cnt) + 16'd1;
                if (w_rise_done && !w_pressed) begin
                    w_release  = 1'b1;
                    n_last_dur = i_item.now_ticks - r_press_start;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_UP;
            r_fall_cnt    <= 16'd0;
            r_rise_cnt    <= 16'd0;
            r_press_start <= 32'd0;
            r_last_dur    <= 32'd0;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_fall_cnt    <= n_fall_cnt;
            r_rise_cnt    <= n_rise_cnt;
            r_press_start <= n_press_start;
            r_last_dur    <= n_last_dur;
        end
    end

    assign o_result.debounced_phase = n_phase;
    assign o_result.press_event     = w_press;
    assign o_result.release_event   = w_release;
    assign o_result.press_duration  = n_last_dur;

    `ASSERT_NEXT(a_press_goes_down, i_clk, i_rst_n, i_fire && w_press,
        r_phase == PH_DOWN && r_press_start == $past(i_item.now_ticks),
        "confirmed press did not land in down with timestamp")
    `ASSERT_NEXT(a_release_duration, i_clk, i_rst_n, i_fire && w_release,
        r_phase == PH_UP && r_last_dur == $past(i_item.now_ticks - r_press_start),
        "confirmed release gave wrong duration")

endmodule

FILE: dv/bdpt_checker.sv
// ----------------------------------------------------------------------------
// bdpt_checker
// watches the tick, result and register channels, steps its own debounce
// machine per accepted tick and compares each result beat in order
// ----------------------------------------------------------------------------
module bdpt_checker #(
    parameter logic [2:0] LIMIT_ADDR = 3'd0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,   // button_level, now_ticks[31:0], zero pad
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,   // debounced_phase[1:0], press_event,
                                     // release_event, press_duration[31:0], zero pad
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_outstanding,
    output int          o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    import bdpt_pkg::*;

    logic [15:0] limit_q;
    t_phase      phase_q;
    logic [15:0] fall_cnt;
    logic [15:0] rise_cnt;
    logic [31:0] press_stamp;
    logic [31:0] held_duration;

    t_result     pending_reports[$];
    t_result     want;
    t_result     seen;
    int          mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    // one update tick of the debounce machine
    task automatic debounce_tick(input t_item tick, output t_result report);
        logic pressed;
        logic press_ev;
        logic release_ev;
        pressed    = ~tick.button_level;
        press_ev   = 1'b0;
        release_ev = 1'b0;
        case (phase_q)
            PH_UP: begin
                if (pressed) phase_q = PH_FALLING;
            end
            PH_FALLING: begin
                if (fall_cnt >= limit_q) begin
                    if (pressed) begin
                        phase_q     = PH_DOWN;
                        press_stamp = tick.now_ticks;
                        press_ev    = 1'b1;
                    end else begin
                        phase_q = PH_UP;
                    end
                    fall_cnt = '0;
                end
                // counter restarts at one after a decision
                fall_cnt = fall_cnt + 16'd1;
            end
            PH_DOWN: begin
                if (!pressed) phase_q = PH_RISING;
            end
            default: begin
                if (rise_cnt >= limit_q) begin
                    if (!pressed) begin
                        phase_q       = PH_UP;
                        held_duration = tick.now_ticks - press_stamp;
                        release_ev    = 1'b1;
                    end else begin
                        phase_q = PH_DOWN;
                    end
                    rise_cnt = '0;
                end
                rise_cnt = rise_cnt + 16'd1;
            end
        endcase
        report.debounced_phase = phase_q;
        report.press_event     = press_ev;
        report.release_event   = release_ev;
        report.press_duration  = held_duration;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            limit_q       = DEBOUNCE_RESET;
            phase_q       = PH_UP;
            fall_cnt      = '0;
            rise_cnt      = '0;
            press_stamp   = '0;
            held_duration = '0;
            pending_reports.delete();
            o_outstanding <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == LIMIT_ADDR)
                limit_q = i_pwdata[15:0];

            // results first: a result beat never belongs to a tick of the same edge
            if (i_m_tvalid && i_m_tready) begin
                seen = t_result'(i_m_tdata[$bits(t_result)-1:0]);
                if (pending_reports.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result beat with nothing expected, got %h",
                             $time, i_m_tdata);
                end else begin
                    want = pending_reports.pop_front();
                    if (seen !== want) begin
                        mismatch_count++;
                        $display({"%0t: result mismatch: phase exp %0d got %0d, ",
                                  "press exp %b got %b, release exp %b got %b, ",
                                  "duration exp %h got %h"},
                                 $time, want.debounced_phase, seen.debounced_phase,
                                 want.press_event, seen.press_event,
                                 want.release_event, seen.release_event,
                                 want.press_duration, seen.press_duration);
                    end
                end
            end

            if (i_s_tvalid && i_s_tready) begin
                debounce_tick(t_item'(i_s_tdata[$bits(t_item)-1:0]), want);
                pending_reports.push_back(want);
            end

            o_outstanding <= pending_reports.size();
        end
    end

endmodule

FILE: dv/tb_button_debounce_press_timer.sv
// ----------------------------------------------------------------------------
// tb_button_debounce_press_timer
// drives update ticks with random gaps and result stalls, walks the debounce
// limit through several values and gives the verdict from the checker
// ----------------------------------------------------------------------------
module tb_button_debounce_press_timer;
    timeunit 1ns;
    timeprecision 1ps;

    import bdpt_pkg::*;

    localparam logic [2:0] LIMIT_ADDR     = {REG_DEBOUNCE_LIMIT, 2'b00};
    localparam int         WATCHDOG_LIMIT = 1000;
    localparam int         HOLD_CYCLES    = 300;

    logic        i_clk;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [39:0] s_tdata  = '0;
    logic        o_m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] o_m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int          outstanding;
    int          mismatches;
    int          quiet_cycles = 0;

    bit          tx_idle     = 1'b1;
    bit          rx_idle     = 1'b1;
    bit          rx_hold_req = 1'b0;
    bit          btn_held    = 1'b0;
    logic [31:0] tick_now    = '0;

    button_debounce_press_timer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    bdpt_checker #(.LIMIT_ADDR(LIMIT_ADDR)) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (o_m_tdata),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .o_outstanding (outstanding),
        .o_mismatches  (mismatches)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int stall;
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            stall = rx_idle ? $urandom_range(0, 15) : 0;
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_tick(input logic level, input logic [31:0] stamp);
        int gap;
        gap = tx_idle ? $urandom_range(0, 15) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(40 - $bits(t_item)){1'b0}}, stamp, level};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // register write once every result is out and the pipe has drained
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (8) @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // mostly clean holds long enough to confirm an edge, some glitch bursts
    // at the opposite level, and a little pure noise
    task automatic run_phase(input logic [15:0] lim, input int count, input bit squeeze);
        int   run_len;
        int   pick;
        bit   noisy;
        logic run_level;
        run_len   = 0;
        noisy     = 1'b0;
        run_level = 1'b1;
        apb_write(LIMIT_ADDR, {16'd0, lim});
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
        if (squeeze) begin
            tx_idle     = 1'b0;
            rx_hold_req = 1'b1;
        end
        repeat (count) begin
            if (run_len == 0) begin
                pick  = $urandom_range(0, 9);
                noisy = (pick == 9);
                if (pick < 7) begin
                    btn_held = ~btn_held;
                    run_len  = (lim > 16'd100) ? count : int'(lim) + $urandom_range(2, 4);
                end else if (pick < 9) begin
                    run_len = $urandom_range(1, (lim < 16'd6 ? int'(lim) : 6) + 1);
                end else begin
                    run_len = $urandom_range(1, 4);
                end
                // active low: pressed means level 0
                run_level = (pick < 7) ? ~btn_held : btn_held;
            end
            if ($urandom_range(0, 15) == 0)
                tick_now = $urandom();
            else
                tick_now = tick_now + $urandom_range(0, 3);
            send_tick(noisy ? 1'($urandom_range(0, 1)) : run_level, tick_now);
            run_len--;
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset limit: stay up, start a fall, one counted tick
        send_tick(1'b1, 32'h0000_0000);
        send_tick(1'b0, 32'hFFFF_FFFF);
        send_tick(1'b1, 32'h0000_0005);

        // zero limit: fall aborted, press confirmed, release bounce, release
        apb_write(LIMIT_ADDR, 32'd0);
        send_tick(1'b1, 32'h0000_0006);
        send_tick(1'b0, 32'h0000_0007);
        send_tick(1'b0, 32'hFFFF_FFFF);
        send_tick(1'b0, 32'h0000_000A);
        send_tick(1'b1, 32'h0000_000B);
        send_tick(1'b0, 32'h0000_000C);
        send_tick(1'b1, 32'h0000_000D);
        send_tick(1'b1, 32'h0000_0004);   // duration wraps past zero
        send_tick(1'b0, 32'h0000_0000);
        send_tick(1'b0, 32'h0000_0000);
        send_tick(1'b1, 32'h0000_0001);
        send_tick(1'b1, 32'hFFFF_FFFF);

        // limit 65534: fall never decides, then a lower limit decides at once
        apb_write(LIMIT_ADDR, 32'd65534);
        repeat (6) send_tick(1'b0, 32'h5555_5555);
        apb_write(LIMIT_ADDR, 32'd2);
        send_tick(1'b0, 32'hAAAA_AAAA);
        send_tick(1'b1, 32'hAAAA_AAAB);
        send_tick(1'b1, 32'hAAAA_AAAC);
        send_tick(1'b1, 32'h2AAA_AAAD);

        run_phase(16'd1, 110, 1'b0);
        run_phase(16'd0, 100, 1'b0);
        run_phase(16'd40, 140, 1'b1);
        run_phase(16'd65534, 12, 1'b0);
        run_phase(16'd3, 110, 1'b0);
        run_phase(16'd2, 110, 1'b0);
        run_phase(16'($urandom_range(0, 12)), 110, 1'b0);
        run_phase(16'd7, 110, 1'b0);
        run_phase(16'd16, 110, 1'b0);
        run_phase(16'd5, 110, 1'b0);
        run_phase(16'($urandom_range(0, 10)), 110, 1'b0);

        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/bdpt_pkg.sv
hdl/bdpt_cfg.sv
hdl/bdpt_fsm.sv
hdl/button_debounce_press_timer.sv
dv/bdpt_checker.sv
dv/tb_button_debounce_press_timer.sv
